### design/awc_pkg.sv
// Shared types and constants of the add-with-carry instruction unit.
package awc_pkg;

    // Fetch sequence phases; the idle phase also means the unit is halted.
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_OPCODE = 3'd1;
    localparam logic [2:0] PH_OPLO   = 3'd2;
    localparam logic [2:0] PH_OPHI   = 3'd3;
    localparam logic [2:0] PH_PTRLO  = 3'd4;
    localparam logic [2:0] PH_PTRHI  = 3'd5;
    localparam logic [2:0] PH_DATA   = 3'd6;

    // Addressing modes.
    localparam logic [2:0] MODE_IMM  = 3'd0;
    localparam logic [2:0] MODE_ZP   = 3'd1;
    localparam logic [2:0] MODE_ZPX  = 3'd2;
    localparam logic [2:0] MODE_ABS  = 3'd3;
    localparam logic [2:0] MODE_ABSX = 3'd4;
    localparam logic [2:0] MODE_ABSY = 3'd5;
    localparam logic [2:0] MODE_INDX = 3'd6;
    localparam logic [2:0] MODE_INDY = 3'd7;

    // Opcodes of the add-with-carry family.
    localparam logic [7:0] OP_ADC_IMM  = 8'h69;
    localparam logic [7:0] OP_ADC_ZP   = 8'h65;
    localparam logic [7:0] OP_ADC_ZPX  = 8'h75;
    localparam logic [7:0] OP_ADC_ABS  = 8'h6D;
    localparam logic [7:0] OP_ADC_ABSX = 8'h7D;
    localparam logic [7:0] OP_ADC_ABSY = 8'h79;
    localparam logic [7:0] OP_ADC_INDX = 8'h61;
    localparam logic [7:0] OP_ADC_INDY = 8'h71;

    // Status byte bit positions.
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_D = 3;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    // Input commands carried on tuser.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [2:0] REG_START_PC    = 3'd0;
    localparam logic [2:0] REG_START_ACC   = 3'd1;
    localparam logic [2:0] REG_START_FLAGS = 3'd2;
    localparam logic [2:0] REG_INDEX_X     = 3'd3;
    localparam logic [2:0] REG_INDEX_Y     = 3'd4;

    localparam int OUT_TDATA_W = 40;

    // Fields of one result transfer.
    typedef struct packed {
        logic        unimplemented;
        logic        instruction_done;
        logic [7:0]  flags_out;
        logic [7:0]  accumulator_out;
        logic        read_wanted;
        logic [15:0] read_address;
    } result_t;

endpackage

### design/add_with_carry_instruction_unit.sv
// Top level of the add-with-carry instruction unit.
//
// The unit runs the add-with-carry instructions of a small 8-bit core one
// memory byte at a time. The input stream (s_axis) carries a command in
// tuser: a start transfer loads the program counter, accumulator and status
// byte from the configuration registers, and a byte transfer hands back the
// data read from the address that was last asked for. Every accepted input
// transfer produces exactly one result transfer on m_axis, which names the
// next address wanted and shows the accumulator, the status byte and whether
// this byte finished an instruction or hit an opcode that is not an add.
// After such an opcode the unit halts and ignores bytes until the next start.
//
// Each input byte is decoded by single-pass logic into the output register,
// so a result appears in the cycle after its input transfer and one item can
// be taken every cycle. While the receiver stalls, the held result blocks
// new input; the input side is ready whenever the output register is empty
// or is being drained in the same cycle.
//
// Reset clears the state and leaves the unit halted, waiting for a start.
// The APB port writes and reads the five start and index registers.
module add_with_carry_instruction_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] read_data
    input  logic        s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] read_address, [16] read_wanted, [24:17] accumulator_out,
    // [32:25] flags_out, [33] instruction_done, [34] unimplemented, rest zero
    output logic [39:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] start_pc_reg;
    logic [7:0]  start_acc_reg;
    logic [7:0]  start_flags_reg;
    logic [7:0]  index_x_reg;
    logic [7:0]  index_y_reg;

    logic [7:0]  acc_reg, acc_next;
    logic [7:0]  flags_reg, flags_next;
    logic [15:0] pc_reg, pc_next;
    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  mode_reg, mode_next;
    logic [7:0]  oplo_reg, oplo_next;
    logic [15:0] waddr_reg, waddr_next;

    logic                  out_valid_reg;
    awc_pkg::result_t      out_reg, out_next;

    logic        in_xfer;
    logic        cfg_write;
    logic [2:0]  reg_index;

    // Decoder and adder signals.
    logic        op_valid;
    logic [2:0]  op_mode;
    logic [15:0] pc_inc;
    logic [15:0] base_sum;
    logic [15:0] ptr_sum;
    logic [4:0]  low_digit;
    logic [9:0]  sum_bin;
    logic [9:0]  sum_adj;
    logic [9:0]  sum_dec;
    logic [7:0]  add_flags;
    logic [7:0]  add_acc;
    logic        carry_in;

    assign pready        = 1'b1;
    assign reg_index     = paddr[4:2];
    assign cfg_write     = psel && penable && pwrite && pready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(awc_pkg::OUT_TDATA_W - $bits(awc_pkg::result_t)){1'b0}}, out_reg};

    always_comb
    begin
        case (reg_index)
            awc_pkg::REG_START_PC:    prdata = {16'h0, start_pc_reg};
            awc_pkg::REG_START_ACC:   prdata = {24'h0, start_acc_reg};
            awc_pkg::REG_START_FLAGS: prdata = {24'h0, start_flags_reg};
            awc_pkg::REG_INDEX_X:     prdata = {24'h0, index_x_reg};
            awc_pkg::REG_INDEX_Y:     prdata = {24'h0, index_y_reg};
            default:                  prdata = 32'h0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pc_reg    <= '0;
            start_acc_reg   <= '0;
            start_flags_reg <= '0;
            index_x_reg     <= '0;
            index_y_reg     <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                awc_pkg::REG_START_PC:    start_pc_reg    <= pwdata[15:0];
                awc_pkg::REG_START_ACC:   start_acc_reg   <= pwdata[7:0];
                awc_pkg::REG_START_FLAGS: start_flags_reg <= pwdata[7:0];
                awc_pkg::REG_INDEX_X:     index_x_reg     <= pwdata[7:0];
                awc_pkg::REG_INDEX_Y:     index_y_reg     <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        op_valid = 1'b1;
        case (s_axis_tdata)
            awc_pkg::OP_ADC_IMM:  op_mode = awc_pkg::MODE_IMM;
            awc_pkg::OP_ADC_ZP:   op_mode = awc_pkg::MODE_ZP;
            awc_pkg::OP_ADC_ZPX:  op_mode = awc_pkg::MODE_ZPX;
            awc_pkg::OP_ADC_ABS:  op_mode = awc_pkg::MODE_ABS;
            awc_pkg::OP_ADC_ABSX: op_mode = awc_pkg::MODE_ABSX;
            awc_pkg::OP_ADC_ABSY: op_mode = awc_pkg::MODE_ABSY;
            awc_pkg::OP_ADC_INDX: op_mode = awc_pkg::MODE_INDX;
            awc_pkg::OP_ADC_INDY: op_mode = awc_pkg::MODE_INDY;
            default:
            begin
                op_mode  = awc_pkg::MODE_IMM;
                op_valid = 1'b0;
            end
        endcase
    end

    // Binary and decimal add. In decimal mode, Z comes from the binary sum
    // and N and V from the sum after the low digit has been adjusted.
    always_comb
    begin
        carry_in  = flags_reg[awc_pkg::FLAG_C];
        sum_bin   = {2'b00, s_axis_tdata} + {2'b00, acc_reg} + {9'h0, carry_in};
        low_digit = {1'b0, acc_reg[3:0]} + {1'b0, s_axis_tdata[3:0]} + {4'h0, carry_in};
        sum_adj   = (low_digit > 5'd9) ? sum_bin + 10'd6 : sum_bin;
        sum_dec   = (sum_adj > 10'h099) ? sum_adj + 10'd96 : sum_adj;

        add_flags = flags_reg;
        add_flags[awc_pkg::FLAG_Z] = (sum_bin[7:0] == 8'h00);
        if (flags_reg[awc_pkg::FLAG_D])
        begin
            add_flags[awc_pkg::FLAG_N] = sum_adj[7];
            add_flags[awc_pkg::FLAG_V] = !(acc_reg[7] ^ s_axis_tdata[7])
                                         && (acc_reg[7] ^ sum_adj[7]);
            add_flags[awc_pkg::FLAG_C] = (sum_dec > 10'h099);
            add_acc = sum_dec[7:0];
        end
        else
        begin
            add_flags[awc_pkg::FLAG_N] = sum_bin[7];
            add_flags[awc_pkg::FLAG_V] = !(acc_reg[7] ^ s_axis_tdata[7])
                                         && (acc_reg[7] ^ sum_bin[7]);
            add_flags[awc_pkg::FLAG_C] = sum_bin[8];
            add_acc = sum_bin[7:0];
        end
    end

    assign pc_inc   = pc_reg + 16'd1;
    assign base_sum = {s_axis_tdata, oplo_reg}
                      + ((mode_reg == awc_pkg::MODE_ABSX) ? {8'h0, index_x_reg} :
                         (mode_reg == awc_pkg::MODE_ABSY) ? {8'h0, index_y_reg} : 16'h0);
    assign ptr_sum  = {s_axis_tdata, oplo_reg}
                      + ((mode_reg == awc_pkg::MODE_INDY) ? {8'h0, index_y_reg} : 16'h0);

    always_comb
    begin
        acc_next   = acc_reg;
        flags_next = flags_reg;
        pc_next    = pc_reg;
        phase_next = phase_reg;
        mode_next  = mode_reg;
        oplo_next  = oplo_reg;
        waddr_next = waddr_reg;

        out_next.read_address     = 16'h0;
        out_next.read_wanted      = 1'b0;
        out_next.instruction_done = 1'b0;
        out_next.unimplemented    = 1'b0;

        if (s_axis_tuser == awc_pkg::CMD_START)
        begin
            pc_next    = start_pc_reg;
            acc_next   = start_acc_reg;
            flags_next = start_flags_reg;
            phase_next = awc_pkg::PH_OPCODE;
            out_next.read_address = start_pc_reg;
            out_next.read_wanted  = 1'b1;
        end
        else
        begin
            case (phase_reg)
                awc_pkg::PH_IDLE:
                begin
                end
                awc_pkg::PH_OPCODE:
                begin
                    pc_next = pc_inc;
                    if (!op_valid)
                    begin
                        out_next.unimplemented = 1'b1;
                        phase_next = awc_pkg::PH_IDLE;
                    end
                    else
                    begin
                        mode_next  = op_mode;
                        waddr_next = pc_inc;
                        out_next.read_address = pc_inc;
                        out_next.read_wanted  = 1'b1;
                        if (op_mode == awc_pkg::MODE_IMM)
                        begin
                            phase_next = awc_pkg::PH_DATA;
                            pc_next    = pc_inc + 16'd1;
                        end
                        else
                        begin
                            phase_next = awc_pkg::PH_OPLO;
                        end
                    end
                end
                awc_pkg::PH_OPLO:
                begin
                    pc_next   = pc_inc;
                    oplo_next = s_axis_tdata;
                    case (mode_reg)
                        awc_pkg::MODE_ZP:
                        begin
                            waddr_next = {8'h0, s_axis_tdata};
                            phase_next = awc_pkg::PH_DATA;
                        end
                        awc_pkg::MODE_ZPX:
                        begin
                            waddr_next = {8'h0, s_axis_tdata + index_x_reg};
                            phase_next = awc_pkg::PH_DATA;
                        end
                        awc_pkg::MODE_INDX:
                        begin
                            waddr_next = {8'h0, s_axis_tdata + index_x_reg};
                            phase_next = awc_pkg::PH_PTRLO;
                        end
                        awc_pkg::MODE_INDY:
                        begin
                            waddr_next = {8'h0, s_axis_tdata};
                            phase_next = awc_pkg::PH_PTRLO;
                        end
                        default:
                        begin
                            waddr_next = pc_inc;
                            phase_next = awc_pkg::PH_OPHI;
                        end
                    endcase
                    out_next.read_address = waddr_next;
                    out_next.read_wanted  = 1'b1;
                end
                awc_pkg::PH_OPHI:
                begin
                    pc_next    = pc_inc;
                    waddr_next = base_sum;
                    phase_next = awc_pkg::PH_DATA;
                    out_next.read_address = base_sum;
                    out_next.read_wanted  = 1'b1;
                end
                awc_pkg::PH_PTRLO:
                begin
                    // The high pointer byte stays in page zero.
                    oplo_next  = s_axis_tdata;
                    waddr_next = {8'h0, waddr_reg[7:0] + 8'd1};
                    phase_next = awc_pkg::PH_PTRHI;
                    out_next.read_address = waddr_next;
                    out_next.read_wanted  = 1'b1;
                end
                awc_pkg::PH_PTRHI:
                begin
                    waddr_next = ptr_sum;
                    phase_next = awc_pkg::PH_DATA;
                    out_next.read_address = ptr_sum;
                    out_next.read_wanted  = 1'b1;
                end
                awc_pkg::PH_DATA:
                begin
                    acc_next   = add_acc;
                    flags_next = add_flags;
                    phase_next = awc_pkg::PH_OPCODE;
                    out_next.instruction_done = 1'b1;
                    out_next.read_address     = pc_reg;
                    out_next.read_wanted      = 1'b1;
                end
                default:
                begin
                    phase_next = awc_pkg::PH_IDLE;
                end
            endcase
        end

        out_next.accumulator_out = acc_next;
        out_next.flags_out       = flags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            flags_reg <= '0;
            pc_reg    <= '0;
            phase_reg <= awc_pkg::PH_IDLE;
            mode_reg  <= awc_pkg::MODE_IMM;
            oplo_reg  <= '0;
            waddr_reg <= '0;
        end
        else if (in_xfer)
        begin
            acc_reg   <= acc_next;
            flags_reg <= flags_next;
            pc_reg    <= pc_next;
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
            oplo_reg  <= oplo_next;
            waddr_reg <= waddr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_reg <= out_next;
        end
    end

endmodule

### design/awc_checker.sv
// Port-level checker of the add-with-carry instruction unit and its bind.
module awc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    logic [15:0] read_address;
    logic        read_wanted;
    logic        instruction_done;
    logic        unimplemented;

    assign read_address     = m_axis_tdata[15:0];
    assign read_wanted      = m_axis_tdata[16];
    assign instruction_done = m_axis_tdata[33];
    assign unimplemented    = m_axis_tdata[34];

    // A result with no request always names address zero.
    a_no_request_zero_address: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !read_wanted) |-> (read_address == 16'h0))
        else $error("read_address is nonzero without a request");

    // A finished add always asks for the next opcode.
    a_done_requests: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && instruction_done) |-> (read_wanted && !unimplemented))
        else $error("completed instruction did not request the next opcode");

    // An unknown opcode halts the unit, so nothing is requested.
    a_unimpl_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && unimplemented) |-> !read_wanted)
        else $error("unimplemented opcode still requested a read");

    // A stalled result holds.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind add_with_carry_instruction_unit awc_checker u_awc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the add-with-carry instruction unit.
module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 1150;
    localparam logic [7:0] ADC_OPCODES [8] = '{awc_pkg::OP_ADC_IMM, awc_pkg::OP_ADC_ZP,
                                               awc_pkg::OP_ADC_ZPX, awc_pkg::OP_ADC_ABS,
                                               awc_pkg::OP_ADC_ABSX, awc_pkg::OP_ADC_ABSY,
                                               awc_pkg::OP_ADC_INDX, awc_pkg::OP_ADC_INDY};
    // Opcodes that sit next to the absolute adds but are not adds.
    localparam logic [7:0] OP_NOT_ADC_ABS  = 8'h60;
    localparam logic [7:0] OP_NOT_ADC_ABSX = 8'h70;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] read_data
    logic        s_axis_tuser;   // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [15:0] read_address, [16] read_wanted, [24:17] accumulator_out,
    // [32:25] flags_out, [33] instruction_done, [34] unimplemented, rest zero
    logic [39:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Mirror of the configuration registers.
    logic [15:0] cfg_pc;
    logic [7:0]  cfg_acc;
    logic [7:0]  cfg_flags;
    logic [7:0]  cfg_x;
    logic [7:0]  cfg_y;

    // Architectural state as the core should see it.
    logic [7:0]  core_acc;
    logic [7:0]  core_status;
    logic [15:0] core_pc;
    logic [2:0]  core_phase;
    logic [2:0]  core_mode;
    logic [7:0]  core_operand_lo;
    logic [15:0] core_addr;
    logic        core_halted;

    awc_pkg::result_t expected_results[$];
    int          mismatches;
    int          items_sent;
    int          cycles;
    bit          steady;

    add_with_carry_instruction_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Binary or decimal add of one data byte into the accumulator.
    function automatic void add_to_accumulator(input logic [7:0] src);
        int unsigned a;
        int unsigned c;
        int unsigned t;
        logic [7:0]  f;
        logic        carry;
        a = 32'(core_acc);
        c = 32'(core_status[awc_pkg::FLAG_C]);
        t = 32'(src) + a + c;
        f = core_status;
        f[awc_pkg::FLAG_Z] = ((t & 32'hFF) == 0);
        if (core_status[awc_pkg::FLAG_D])
        begin
            if ((a & 32'hF) + (32'(src) & 32'hF) + c > 9)
                t = t + 6;
            f[awc_pkg::FLAG_N] = t[7];
            f[awc_pkg::FLAG_V] = ~(a[7] ^ src[7]) & (a[7] ^ t[7]);
            if (t > 32'h99)
                t = t + 96;
            carry = (t > 32'h99);
        end
        else
        begin
            f[awc_pkg::FLAG_N] = t[7];
            f[awc_pkg::FLAG_V] = ~(a[7] ^ src[7]) & (a[7] ^ t[7]);
            carry = (t > 32'hFF);
        end
        f[awc_pkg::FLAG_C] = carry;
        core_status = f;
        core_acc = t[7:0];
    endfunction

    // Advances the core state by one accepted transfer and queues the result.
    function automatic void predict_transfer(input logic cmd, input logic [7:0] b);
        awc_pkg::result_t r;
        logic [15:0] req;
        logic        want;
        logic        done;
        logic        unimpl;
        logic [2:0]  mode;
        req = '0;
        want = 1'b0;
        done = 1'b0;
        unimpl = 1'b0;
        mode = awc_pkg::MODE_IMM;
        if (!(cmd == awc_pkg::CMD_BYTE && core_halted))
            items_sent++;
        if (cmd == awc_pkg::CMD_START)
        begin
            core_pc = cfg_pc;
            core_acc = cfg_acc;
            core_status = cfg_flags;
            core_halted = 1'b0;
            core_phase = awc_pkg::PH_OPCODE;
            req = core_pc;
            want = 1'b1;
        end
        else if (!core_halted)
        begin
            case (core_phase)
                awc_pkg::PH_OPCODE:
                begin
                    core_pc = core_pc + 16'd1;
                    case (b)
                        awc_pkg::OP_ADC_IMM:  mode = awc_pkg::MODE_IMM;
                        awc_pkg::OP_ADC_ZP:   mode = awc_pkg::MODE_ZP;
                        awc_pkg::OP_ADC_ZPX:  mode = awc_pkg::MODE_ZPX;
                        awc_pkg::OP_ADC_ABS:  mode = awc_pkg::MODE_ABS;
                        awc_pkg::OP_ADC_ABSX: mode = awc_pkg::MODE_ABSX;
                        awc_pkg::OP_ADC_ABSY: mode = awc_pkg::MODE_ABSY;
                        awc_pkg::OP_ADC_INDX: mode = awc_pkg::MODE_INDX;
                        awc_pkg::OP_ADC_INDY: mode = awc_pkg::MODE_INDY;
                        default:              unimpl = 1'b1;
                    endcase
                    if (unimpl)
                    begin
                        core_halted = 1'b1;
                        core_phase = awc_pkg::PH_IDLE;
                    end
                    else
                    begin
                        core_mode = mode;
                        core_addr = core_pc;
                        core_phase = (mode == awc_pkg::MODE_IMM) ? awc_pkg::PH_DATA
                                                                 : awc_pkg::PH_OPLO;
                        req = core_pc;
                        want = 1'b1;
                        if (mode == awc_pkg::MODE_IMM)
                            core_pc = core_pc + 16'd1;
                    end
                end
                awc_pkg::PH_OPLO:
                begin
                    core_pc = core_pc + 16'd1;
                    core_operand_lo = b;
                    case (core_mode)
                        awc_pkg::MODE_ZP:
                        begin
                            core_addr = {8'h00, b};
                            core_phase = awc_pkg::PH_DATA;
                        end
                        awc_pkg::MODE_ZPX:
                        begin
                            core_addr = {8'h00, b + cfg_x};
                            core_phase = awc_pkg::PH_DATA;
                        end
                        awc_pkg::MODE_INDX:
                        begin
                            core_addr = {8'h00, b + cfg_x};
                            core_phase = awc_pkg::PH_PTRLO;
                        end
                        awc_pkg::MODE_INDY:
                        begin
                            core_addr = {8'h00, b};
                            core_phase = awc_pkg::PH_PTRLO;
                        end
                        default:
                        begin
                            core_addr = core_pc;
                            core_phase = awc_pkg::PH_OPHI;
                        end
                    endcase
                    req = core_addr;
                    want = 1'b1;
                end
                awc_pkg::PH_OPHI:
                begin
                    core_pc = core_pc + 16'd1;
                    core_addr = {b, core_operand_lo};
                    if (core_mode == awc_pkg::MODE_ABSX)
                        core_addr = core_addr + {8'h00, cfg_x};
                    else if (core_mode == awc_pkg::MODE_ABSY)
                        core_addr = core_addr + {8'h00, cfg_y};
                    core_phase = awc_pkg::PH_DATA;
                    req = core_addr;
                    want = 1'b1;
                end
                awc_pkg::PH_PTRLO:
                begin
                    core_operand_lo = b;
                    // The pointer high byte stays within page zero.
                    core_addr = {8'h00, core_addr[7:0] + 8'd1};
                    core_phase = awc_pkg::PH_PTRHI;
                    req = core_addr;
                    want = 1'b1;
                end
                awc_pkg::PH_PTRHI:
                begin
                    core_addr = {b, core_operand_lo};
                    if (core_mode == awc_pkg::MODE_INDY)
                        core_addr = core_addr + {8'h00, cfg_y};
                    core_phase = awc_pkg::PH_DATA;
                    req = core_addr;
                    want = 1'b1;
                end
                awc_pkg::PH_DATA:
                begin
                    add_to_accumulator(b);
                    done = 1'b1;
                    core_phase = awc_pkg::PH_OPCODE;
                    req = core_pc;
                    want = 1'b1;
                end
                default:
                begin
                    core_halted = 1'b1;
                    core_phase = awc_pkg::PH_IDLE;
                end
            endcase
        end
        r.read_address = want ? req : 16'h0000;
        r.read_wanted = want;
        r.accumulator_out = core_acc;
        r.flags_out = core_status;
        r.instruction_done = done;
        r.unimplemented = unimpl;
        expected_results.push_back(r);
    endfunction

    function automatic void report_mismatch(input awc_pkg::result_t want,
                                            input awc_pkg::result_t got,
                                            input logic [4:0] pad);
        $display("mismatch: expected addr %h req %b acc %h flags %h done %b unimpl %b",
                 want.read_address, want.read_wanted, want.accumulator_out,
                 want.flags_out, want.instruction_done, want.unimplemented);
        $display("  actual addr %h req %b acc %h flags %h done %b unimpl %b pad %h",
                 got.read_address, got.read_wanted, got.accumulator_out,
                 got.flags_out, got.instruction_done, got.unimplemented, pad);
    endfunction

    task automatic send_item(input logic cmd, input logic [7:0] b);
        int   gap;
        logic ok;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= cmd;
        do
        begin
            @(negedge clk);
            ok = s_axis_tready;
            @(posedge clk);
        end
        while (!ok);
        predict_transfer(cmd, b);
    endtask

    // Holds off the input side until every queued result has been taken.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            awc_pkg::REG_START_PC:    cfg_pc = value;
            awc_pkg::REG_START_ACC:   cfg_acc = value[7:0];
            awc_pkg::REG_START_FLAGS: cfg_flags = value[7:0];
            awc_pkg::REG_INDEX_X:     cfg_x = value[7:0];
            awc_pkg::REG_INDEX_Y:     cfg_y = value[7:0];
            default:                  ;
        endcase
    endtask

    task automatic configure(input logic [15:0] pc, input logic [7:0] acc,
                             input logic [7:0] flags, input logic [7:0] x,
                             input logic [7:0] y);
        write_register(awc_pkg::REG_START_PC, pc);
        write_register(awc_pkg::REG_START_ACC, {8'h00, acc});
        write_register(awc_pkg::REG_START_FLAGS, {8'h00, flags});
        write_register(awc_pkg::REG_INDEX_X, {8'h00, x});
        write_register(awc_pkg::REG_INDEX_Y, {8'h00, y});
    endtask

    function automatic logic [15:0] pick_value(input logic [15:0] top);
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return top;
            default: return 16'($urandom_range(0, top));
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [7:0] corners [4] = '{8'h00, 8'hFF, 8'h80, 8'h7F};
        if ($urandom_range(0, 3) == 0)
            return corners[2'($urandom_range(0, 3))];
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_opcode();
        case ($urandom_range(0, 19))
            16:      return $urandom_range(0, 1) ? OP_NOT_ADC_ABS : OP_NOT_ADC_ABSX;
            17:      return 8'($urandom);
            default: return ADC_OPCODES[3'($urandom_range(0, 7))];
        endcase
    endfunction

    // Out of reset the core is halted with all registers cleared.
    task automatic test_after_reset();
        send_item(awc_pkg::CMD_BYTE, 8'hA5);
        send_item(awc_pkg::CMD_START, 8'h00);
        send_item(awc_pkg::CMD_BYTE, awc_pkg::OP_ADC_IMM);
        send_item(awc_pkg::CMD_BYTE, 8'h00);
        wait_drained();
    endtask

    // Start PC, accumulator and both indexes at their top value, so each index and pointer wraps.
    task automatic test_address_wrap();
        configure(16'hFFFF, 8'hFF, 8'h01, 8'hFF, 8'hFF);
        send_item(awc_pkg::CMD_START, 8'hFF);
        send_item(awc_pkg::CMD_BYTE, awc_pkg::OP_ADC_IMM);
        send_item(awc_pkg::CMD_BYTE, 8'hFF);
        send_item(awc_pkg::CMD_BYTE, awc_pkg::OP_ADC_ZPX);
        send_item(awc_pkg::CMD_BYTE, 8'h80);
        send_item(awc_pkg::CMD_BYTE, 8'h01);
        send_item(awc_pkg::CMD_BYTE, awc_pkg::OP_ADC_ABSX);
        send_item(awc_pkg::CMD_BYTE, 8'hFF);
        send_item(awc_pkg::CMD_BYTE, 8'hFF);
        send_item(awc_pkg::CMD_BYTE, 8'h80);
        send_item(awc_pkg::CMD_BYTE, awc_pkg::OP_ADC_INDX);
        send_item(awc_pkg::CMD_BYTE, 8'h00);
        send_item(awc_pkg::CMD_BYTE, 8'h34);
        send_item(awc_pkg::CMD_BYTE, 8'h12);
        send_item(awc_pkg::CMD_BYTE, 8'h7F);
        send_item(awc_pkg::CMD_BYTE, awc_pkg::OP_ADC_INDY);
        send_item(awc_pkg::CMD_BYTE, 8'hFF);
        send_item(awc_pkg::CMD_BYTE, 8'hFF);
        send_item(awc_pkg::CMD_BYTE, 8'hFF);
        send_item(awc_pkg::CMD_BYTE, 8'h01);
        send_item(awc_pkg::CMD_BYTE, OP_NOT_ADC_ABS);
        wait_drained();
    endtask

    // Decimal adds, a restart in the middle of an instruction and a halt.
    task automatic test_decimal_and_restart();
        configure(16'h1234, 8'h99, 8'h09, 8'h10, 8'h80);
        send_item(awc_pkg::CMD_START, 8'h00);
        send_item(awc_pkg::CMD_BYTE, awc_pkg::OP_ADC_IMM);
        send_item(awc_pkg::CMD_BYTE, 8'h01);
        send_item(awc_pkg::CMD_BYTE, awc_pkg::OP_ADC_ABSY);
        send_item(awc_pkg::CMD_BYTE, 8'hF0);
        send_item(awc_pkg::CMD_BYTE, 8'hFF);
        send_item(awc_pkg::CMD_START, 8'h00);
        send_item(awc_pkg::CMD_BYTE, awc_pkg::OP_ADC_ZP);
        send_item(awc_pkg::CMD_BYTE, 8'h10);
        send_item(awc_pkg::CMD_BYTE, 8'h58);
        send_item(awc_pkg::CMD_BYTE, awc_pkg::OP_ADC_ABS);
        send_item(awc_pkg::CMD_BYTE, 8'h00);
        send_item(awc_pkg::CMD_BYTE, 8'h80);
        send_item(awc_pkg::CMD_BYTE, 8'h99);
        send_item(awc_pkg::CMD_BYTE, OP_NOT_ADC_ABSX);
        wait_drained();
    endtask

    // Well-formed programs with random operands, plus bad opcodes and noise.
    task automatic test_random_programs();
        int count;
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                wait_drained();
                configure(pick_value(16'hFFFF), 8'(pick_value(16'hFF)),
                          8'(pick_value(16'hFF)), 8'(pick_value(16'hFF)),
                          8'(pick_value(16'hFF)));
            end
            steady = ($urandom_range(0, 4) == 0);
            send_item(awc_pkg::CMD_START, pick_byte());
            count = $urandom_range(1, 12);
            repeat (count)
            begin
                if (core_halted)
                    break;
                send_item(awc_pkg::CMD_BYTE, pick_opcode());
                while (!core_halted && core_phase != awc_pkg::PH_OPCODE)
                begin
                    if ($urandom_range(0, 49) == 0)
                        send_item(awc_pkg::CMD_START, pick_byte());
                    else
                        send_item(awc_pkg::CMD_BYTE, pick_byte());
                end
            end
            if ($urandom_range(0, 5) == 0)
            begin
                count = $urandom_range(1, 4);
                repeat (count) send_item(1'($urandom), pick_byte());
            end
            if (core_halted)
            begin
                count = $urandom_range(0, 2);
                repeat (count) send_item(awc_pkg::CMD_BYTE, pick_byte());
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin : result_checker
        int               stall;
        logic             ok;
        awc_pkg::result_t got;
        awc_pkg::result_t want;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                ok = m_axis_tvalid;
                if (ok)
                begin
                    got = awc_pkg::result_t'(m_axis_tdata[34:0]);
                    if (expected_results.size() == 0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("unexpected result transfer %h", m_axis_tdata);
                    end
                    else
                    begin
                        want = expected_results.pop_front();
                        if (got !== want || m_axis_tdata[39:35] !== 5'b0)
                        begin
                            mismatches++;
                            if (mismatches <= 10)
                                report_mismatch(want, got, m_axis_tdata[39:35]);
                        end
                    end
                end
                @(posedge clk);
            end
            while (!ok);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = awc_pkg::CMD_START;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        items_sent = 0;
        steady = 1'b0;
        cfg_pc = '0;
        cfg_acc = '0;
        cfg_flags = '0;
        cfg_x = '0;
        cfg_y = '0;
        core_acc = '0;
        core_status = '0;
        core_pc = '0;
        core_phase = awc_pkg::PH_IDLE;
        core_mode = awc_pkg::MODE_IMM;
        core_operand_lo = '0;
        core_addr = '0;
        core_halted = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_address_wrap();
        test_decimal_and_restart();
        test_random_programs();
        wait_drained();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### files.f
design/awc_pkg.sv
design/add_with_carry_instruction_unit.sv
design/awc_checker.sv
verif/testbench.sv
